@@ hw/rtl/text_mode_console_writer_unit_assert.svh @@
// Assertion macros for the text console writer.
// Clocked on clock and disabled in reset; no other dependencies.
`ifndef TEXT_MODE_CONSOLE_WRITER_UNIT_ASSERT_SVH
`define TEXT_MODE_CONSOLE_WRITER_UNIT_ASSERT_SVH

// same-cycle implication
`define TMCW_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define TMCW_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hw/rtl/tmcw_pkg.sv @@
// Shared types and constants of the text console writer.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package tmcw_pkg;

   localparam int CHAR_W     = 8;
   localparam int ATTR_W     = 8;
   localparam int CELL_W     = CHAR_W + ATTR_W;
   localparam int CURSOR_W   = 11;
   localparam int INDEX_W    = 11;
   localparam int APB_DATA_W = 32;
   localparam int APB_ADDR_W = 3;

   localparam logic [CHAR_W-1:0] CODE_NEWLINE = 8'd10;
   localparam logic [CHAR_W-1:0] CODE_TAB     = 8'd9;
   localparam logic [CHAR_W-1:0] CODE_SPACE   = 8'd32;
   localparam logic [ATTR_W-1:0] RESET_ATTR   = 8'h07;

   localparam logic ACT_PUT  = 1'b0;
   localparam logic ACT_READ = 1'b1;

   localparam logic REG_TEXT_ATTR = 1'b0;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_PUT,
      ST_CLEAR,
      ST_READ
   } tmcw_state_type;

endpackage

@@ hw/rtl/tmcw_csr.sv @@
// Configuration register file: text attribute behind an APB-style port.
// Depends on tmcw_pkg.
`timescale 1ns / 1ps

module tmcw_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [tmcw_pkg::APB_ADDR_W-1:0]   paddr,
   input  logic [tmcw_pkg::APB_DATA_W-1:0]   pwdata,
   output logic [tmcw_pkg::APB_DATA_W-1:0]   prdata,
   output logic                              pready,
   output logic [tmcw_pkg::ATTR_W-1:0]       text_attr
);
   import tmcw_pkg::*;

   logic [ATTR_W-1:0] attr_ff;
   logic [ATTR_W-1:0] attr_in;
   logic              reg_sel;

   assign reg_sel = (paddr[2] == REG_TEXT_ATTR);
   assign pready  = 1'b1;

   always_comb begin
      attr_in = attr_ff;
      if (psel && penable && pwrite && reg_sel) begin
         attr_in = pwdata[ATTR_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         attr_ff <= RESET_ATTR;
      end else begin
         attr_ff <= attr_in;
      end
   end

   assign prdata    = reg_sel ? APB_DATA_W'(attr_ff) : '0;
   assign text_attr = attr_ff;

endmodule

@@ hw/rtl/tmcw_ram.sv @@
// Screen store: one write port, one read port with registered data.
// Depends on tmcw_pkg for the cell width.
`timescale 1ns / 1ps

module tmcw_ram #(
   parameter int DEPTH  = 2000,
   parameter int ADDR_W = 11
) (
   input  logic                        clock,
   input  logic                        we,
   input  logic [ADDR_W-1:0]           waddr,
   input  logic [tmcw_pkg::CELL_W-1:0] wdata,
   input  logic                        re,
   input  logic [ADDR_W-1:0]           raddr,
   output logic [tmcw_pkg::CELL_W-1:0] rdata
);
   import tmcw_pkg::*;

   logic [CELL_W-1:0] store_ff [DEPTH];
   logic [CELL_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         store_ff[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= store_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

@@ hw/rtl/tmcw_ctrl.sv @@
// Console sequencer: cursor tracking, cell writes, clear sweeps and reads.
// Depends on tmcw_pkg and text_mode_console_writer_unit_assert.svh.
`timescale 1ns / 1ps
`include "text_mode_console_writer_unit_assert.svh"

module tmcw_ctrl #(
   parameter int COLUMNS    = 80,
   parameter int ROWS       = 25,
   parameter int TAB_SPACES = 4,
   parameter int ADDR_W     = 11
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic                          req_action,
   input  logic [tmcw_pkg::CHAR_W-1:0]   req_char_code,
   input  logic [tmcw_pkg::INDEX_W-1:0]  req_cell_index,
   input  logic                          req_end_of_text,
   input  logic [tmcw_pkg::ATTR_W-1:0]   text_attr,
   output logic                          ram_we,
   output logic [ADDR_W-1:0]             ram_waddr,
   output logic [tmcw_pkg::CELL_W-1:0]   ram_wdata,
   output logic                          ram_re,
   output logic [ADDR_W-1:0]             ram_raddr,
   input  logic [tmcw_pkg::CELL_W-1:0]   ram_rdata,
   output logic                          rsp_strobe,
   output logic [tmcw_pkg::CURSOR_W-1:0] rsp_cursor_pos,
   output logic [tmcw_pkg::CHAR_W-1:0]   rsp_read_char,
   output logic [tmcw_pkg::ATTR_W-1:0]   rsp_read_attr,
   output logic                          rsp_screen_cleared,
   output logic                          rsp_last_of_text
);
   import tmcw_pkg::*;

   localparam int CELL_COUNT = COLUMNS * ROWS;
   localparam int CUR_W      = $clog2(CELL_COUNT + COLUMNS + 1);
   localparam int COL_W      = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
   localparam int TAB_W      = $clog2(TAB_SPACES + 1);
   localparam int IDX_W      = (ADDR_W > INDEX_W) ? ADDR_W : INDEX_W;

   localparam logic [CUR_W-1:0]  CUR_END   = CUR_W'(CELL_COUNT);
   localparam logic [CUR_W-1:0]  CUR_STEP  = CUR_W'(COLUMNS);
   localparam logic [CUR_W-1:0]  CUR_TAB   = CUR_W'(TAB_SPACES);
   localparam logic [COL_W-1:0]  COL_LAST  = COL_W'(COLUMNS - 1);
   localparam logic [ADDR_W-1:0] ADDR_LAST = ADDR_W'(CELL_COUNT - 1);
   localparam logic [IDX_W-1:0]  IDX_END   = IDX_W'(CELL_COUNT);
   localparam logic [TAB_W-1:0]  TAB_COUNT = TAB_W'(TAB_SPACES);
   localparam logic [TAB_W-1:0]  TAB_ONE   = TAB_W'(1);

   tmcw_state_type    state_ff, state_in;
   logic [CUR_W-1:0]  lin_ff, lin_in;
   logic [CUR_W-1:0]  rowbase_ff, rowbase_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic [ADDR_W-1:0] clr_addr_ff, clr_addr_in;
   logic [TAB_W-1:0]  left_ff, left_in;
   logic [CHAR_W-1:0] ch_ff, ch_in;
   logic              eot_ff, eot_in;
   logic              cleared_ff, cleared_in;
   logic              oob_ff, oob_in;
   logic [CHAR_W-1:0] rd_char_ff, rd_char_in;
   logic [ATTR_W-1:0] rd_attr_ff, rd_attr_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [IDX_W-1:0]  idx_wide;
   logic [CUR_W-1:0]  next_row;

   assign idx_wide = IDX_W'(req_cell_index);
   assign next_row = rowbase_ff + CUR_STEP;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         lin_ff       <= '0;
         rowbase_ff   <= '0;
         col_ff       <= '0;
         clr_addr_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         lin_ff       <= lin_in;
         rowbase_ff   <= rowbase_in;
         col_ff       <= col_in;
         clr_addr_ff  <= clr_addr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      left_ff    <= left_in;
      ch_ff      <= ch_in;
      eot_ff     <= eot_in;
      cleared_ff <= cleared_in;
      oob_ff     <= oob_in;
      rd_char_ff <= rd_char_in;
      rd_attr_ff <= rd_attr_in;
   end

   always_comb begin
      state_in     = state_ff;
      lin_in       = lin_ff;
      rowbase_in   = rowbase_ff;
      col_in       = col_ff;
      clr_addr_in  = clr_addr_ff;
      left_in      = left_ff;
      ch_in        = ch_ff;
      eot_in       = eot_ff;
      cleared_in   = cleared_ff;
      oob_in       = oob_ff;
      rd_char_in   = rd_char_ff;
      rd_attr_in   = rd_attr_ff;
      rsp_valid_in = 1'b0;
      ram_we       = 1'b0;
      ram_waddr    = lin_ff[ADDR_W-1:0];
      ram_wdata    = {text_attr, ch_ff};
      ram_re       = 1'b0;
      ram_raddr    = idx_wide[ADDR_W-1:0];

      unique case (state_ff)
         ST_INIT: begin
            ram_we      = 1'b1;
            ram_waddr   = clr_addr_ff;
            ram_wdata   = {RESET_ATTR, CODE_SPACE};
            clr_addr_in = clr_addr_ff + 1'b1;
            if (clr_addr_ff == ADDR_LAST) begin
               clr_addr_in = '0;
               state_in    = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               eot_in     = req_end_of_text;
               cleared_in = 1'b0;
               rd_char_in = '0;
               rd_attr_in = '0;
               if (req_action == ACT_READ) begin
                  ram_re   = 1'b1;
                  oob_in   = (idx_wide >= IDX_END);
                  state_in = ST_READ;
               end else if (req_char_code == CODE_NEWLINE) begin
                  lin_in     = next_row;
                  rowbase_in = next_row;
                  col_in     = '0;
                  if (next_row >= CUR_END) begin
                     cleared_in = 1'b1;
                     left_in    = '0;
                     state_in   = ST_CLEAR;
                  end else begin
                     rsp_valid_in = 1'b1;
                  end
               end else if (req_char_code == CODE_TAB) begin
                  ch_in    = CODE_SPACE;
                  left_in  = TAB_COUNT;
                  state_in = ST_PUT;
               end else begin
                  ch_in    = req_char_code;
                  left_in  = TAB_ONE;
                  state_in = ST_PUT;
               end
            end
         end
         ST_PUT: begin
            if (lin_ff >= CUR_END) begin
               cleared_in = 1'b1;
               state_in   = ST_CLEAR;
            end else begin
               ram_we  = 1'b1;
               lin_in  = lin_ff + 1'b1;
               left_in = left_ff - 1'b1;
               if (col_ff == COL_LAST) begin
                  col_in     = '0;
                  rowbase_in = next_row;
               end else begin
                  col_in = col_ff + 1'b1;
               end
               if (left_ff == TAB_ONE) begin
                  rsp_valid_in = 1'b1;
                  state_in     = ST_IDLE;
               end
            end
         end
         ST_CLEAR: begin
            ram_we      = 1'b1;
            ram_waddr   = clr_addr_ff;
            ram_wdata   = {text_attr, CODE_SPACE};
            clr_addr_in = clr_addr_ff + 1'b1;
            if (clr_addr_ff == ADDR_LAST) begin
               clr_addr_in = '0;
               lin_in      = '0;
               rowbase_in  = '0;
               col_in      = '0;
               if (left_ff != '0) begin
                  state_in = ST_PUT;
               end else begin
                  rsp_valid_in = 1'b1;
                  state_in     = ST_IDLE;
               end
            end
         end
         ST_READ: begin
            if (!oob_ff) begin
               rd_char_in = ram_rdata[CHAR_W-1:0];
               rd_attr_in = ram_rdata[CELL_W-1:CHAR_W];
            end
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy               = (state_ff != ST_IDLE);
   assign rsp_strobe         = rsp_valid_ff;
   assign rsp_cursor_pos     = CURSOR_W'(lin_ff);
   assign rsp_read_char      = rd_char_ff;
   assign rsp_read_attr      = rd_attr_ff;
   assign rsp_screen_cleared = cleared_ff;
   assign rsp_last_of_text   = eot_ff;

   `TMCW_ASSERT_NOW(a_strobe_in_idle, rsp_valid_ff, state_ff == ST_IDLE, "response outside idle")
   `TMCW_ASSERT_NOW(a_put_in_range, ram_we && (state_ff == ST_PUT), lin_ff < CUR_END, "put past end")
   `TMCW_ASSERT_NOW(a_cursor_bound, state_ff == ST_IDLE, lin_ff <= CUR_END, "cursor past end")
   `TMCW_ASSERT_NOW(a_cursor_split, state_ff == ST_IDLE, lin_ff == rowbase_ff + CUR_W'(col_ff), "row and column out of step")
   `TMCW_ASSERT_NOW(a_clear_cursor, rsp_valid_ff && cleared_ff, lin_ff <= CUR_TAB, "cursor after clear too far")
   `TMCW_ASSERT_NEXT(a_read_issue, start && !busy && (req_action == ACT_READ), state_ff == ST_READ, "read not issued")

endmodule

@@ hw/rtl/text_mode_console_writer_unit.sv @@
// Top level of the text console writer: register file, sequencer, screen store.
// Depends on tmcw_pkg, tmcw_csr, tmcw_ram and tmcw_ctrl.
//
//   channel   ports            handshake
//   request   req_*            accepted when start is high and busy is low
//   response  rsp_*            one cycle, marked by rsp_strobe, never stalled
//   config    psel..pready     APB-style write/read, pready tied high
//
// A character, and each of the TAB_SPACES spaces of a tab, is written from the put state;
// a newline that needs no clear answers from idle, and a read waits on one registered
// memory read. A clear sweeps the store one cell a cycle: after a newline on the last row,
// or when a put hits the end. After reset busy stays high while the store fills with
// spaces; configuration writes are taken during that sweep.
// The receiver cannot stall; a response strobes in the cycle after its last step.
`timescale 1ns / 1ps

module text_mode_console_writer_unit #(
   parameter int COLUMNS    = 80,
   parameter int ROWS       = 25,
   parameter int TAB_SPACES = 4
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic                            req_action,
   input  logic [tmcw_pkg::CHAR_W-1:0]     req_char_code,
   input  logic [tmcw_pkg::INDEX_W-1:0]    req_cell_index,
   input  logic                            req_end_of_text,
   output logic                            rsp_strobe,
   output logic [tmcw_pkg::CURSOR_W-1:0]   rsp_cursor_pos,
   output logic [tmcw_pkg::CHAR_W-1:0]     rsp_read_char,
   output logic [tmcw_pkg::ATTR_W-1:0]     rsp_read_attr,
   output logic                            rsp_screen_cleared,
   output logic                            rsp_last_of_text,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [tmcw_pkg::APB_ADDR_W-1:0] paddr,
   input  logic [tmcw_pkg::APB_DATA_W-1:0] pwdata,
   output logic [tmcw_pkg::APB_DATA_W-1:0] prdata,
   output logic                            pready
);
   import tmcw_pkg::*;

   localparam int CELL_COUNT = COLUMNS * ROWS;
   localparam int ADDR_W     = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;

   logic [ATTR_W-1:0] text_attr;
   logic              ram_we;
   logic [ADDR_W-1:0] ram_waddr;
   logic [CELL_W-1:0] ram_wdata;
   logic              ram_re;
   logic [ADDR_W-1:0] ram_raddr;
   logic [CELL_W-1:0] ram_rdata;

   tmcw_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready),
      .text_attr (text_attr)
   );

   tmcw_ram #(
      .DEPTH  (CELL_COUNT),
      .ADDR_W (ADDR_W)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   tmcw_ctrl #(
      .COLUMNS    (COLUMNS),
      .ROWS       (ROWS),
      .TAB_SPACES (TAB_SPACES),
      .ADDR_W     (ADDR_W)
   ) u_ctrl (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_action         (req_action),
      .req_char_code      (req_char_code),
      .req_cell_index     (req_cell_index),
      .req_end_of_text    (req_end_of_text),
      .text_attr          (text_attr),
      .ram_we             (ram_we),
      .ram_waddr          (ram_waddr),
      .ram_wdata          (ram_wdata),
      .ram_re             (ram_re),
      .ram_raddr          (ram_raddr),
      .ram_rdata          (ram_rdata),
      .rsp_strobe         (rsp_strobe),
      .rsp_cursor_pos     (rsp_cursor_pos),
      .rsp_read_char      (rsp_read_char),
      .rsp_read_attr      (rsp_read_attr),
      .rsp_screen_cleared (rsp_screen_cleared),
      .rsp_last_of_text   (rsp_last_of_text)
   );

endmodule

@@ tb/text_mode_console_writer_unit_tb.sv @@
// Self-checking testbench for text_mode_console_writer_unit: a screen-store predictor
// checks every response, and APB writes move the text attribute between phases.
// Depends on tmcw_pkg and the text_mode_console_writer_unit RTL.
`timescale 1ns / 1ps

module text_mode_console_writer_unit_tb;
   import tmcw_pkg::*;

   localparam int COLUMNS       = 80;
   localparam int ROWS          = 25;
   localparam int TAB_SPACES    = 4;
   localparam int CELL_COUNT    = COLUMNS * ROWS;
   localparam int STALL_LIMIT   = 12000;
   localparam int SETTLE_CYCLES = 8;
   localparam int RANDOM_ITEMS  = 1000;

   localparam logic [APB_ADDR_W-1:0] ATTR_ADDR = {REG_TEXT_ATTR, 2'b00};

   typedef struct packed {
      logic [CURSOR_W-1:0] cursor_pos;
      logic [CHAR_W-1:0]   read_char;
      logic [ATTR_W-1:0]   read_attr;
      logic                screen_cleared;
      logic                last_of_text;
   } console_result_type;

   logic                  clock;
   logic                  reset;
   logic                  start;
   logic                  busy;
   logic                  req_action;
   logic [CHAR_W-1:0]     req_char_code;
   logic [INDEX_W-1:0]    req_cell_index;
   logic                  req_end_of_text;
   logic                  rsp_strobe;
   logic [CURSOR_W-1:0]   rsp_cursor_pos;
   logic [CHAR_W-1:0]     rsp_read_char;
   logic [ATTR_W-1:0]     rsp_read_attr;
   logic                  rsp_screen_cleared;
   logic                  rsp_last_of_text;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [APB_ADDR_W-1:0] paddr;
   logic [APB_DATA_W-1:0] pwdata;
   logic [APB_DATA_W-1:0] prdata;
   logic                  pready;

   logic [CELL_W-1:0]  screen_image [CELL_COUNT];
   int unsigned        cursor_now;
   logic [ATTR_W-1:0]  text_attr;
   console_result_type pending_results[$];
   int                 mismatch_count;
   int                 item_count;
   int                 stall_cycles;
   bit                 no_gaps;

   text_mode_console_writer_unit #(
      .COLUMNS   (COLUMNS),
      .ROWS      (ROWS),
      .TAB_SPACES(TAB_SPACES)
   ) i_dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_action        (req_action),
      .req_char_code     (req_char_code),
      .req_cell_index    (req_cell_index),
      .req_end_of_text   (req_end_of_text),
      .rsp_strobe        (rsp_strobe),
      .rsp_cursor_pos    (rsp_cursor_pos),
      .rsp_read_char     (rsp_read_char),
      .rsp_read_attr     (rsp_read_attr),
      .rsp_screen_cleared(rsp_screen_cleared),
      .rsp_last_of_text  (rsp_last_of_text),
      .psel              (psel),
      .penable           (penable),
      .pwrite            (pwrite),
      .paddr             (paddr),
      .pwdata            (pwdata),
      .prdata            (prdata),
      .pready            (pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic void note_mismatch(string msg);
      mismatch_count++;
      if (mismatch_count <= 10) $display("%s", msg);
   endfunction

   function automatic void blank_screen();
      for (int i = 0; i < CELL_COUNT; i++) screen_image[i] = {text_attr, CODE_SPACE};
      cursor_now = 0;
   endfunction

   function automatic logic store_char(logic [CHAR_W-1:0] code);
      logic wiped;
      wiped = 1'b0;
      if (cursor_now >= CELL_COUNT) begin
         blank_screen();
         wiped = 1'b1;
      end
      screen_image[cursor_now] = {text_attr, code};
      cursor_now++;
      return wiped;
   endfunction

   function automatic console_result_type predict_console(logic action,
                                                          logic [CHAR_W-1:0] code,
                                                          logic [INDEX_W-1:0] index,
                                                          logic eot);
      console_result_type r;
      r = '0;
      r.last_of_text = eot;
      if (action == ACT_READ) begin
         if (index < CELL_COUNT) begin
            r.read_char = screen_image[index][CHAR_W-1:0];
            r.read_attr = screen_image[index][CELL_W-1:CHAR_W];
         end
      end else if (code == CODE_NEWLINE) begin
         cursor_now = (cursor_now / COLUMNS + 1) * COLUMNS;
         if (cursor_now >= CELL_COUNT) begin
            blank_screen();
            r.screen_cleared = 1'b1;
         end
      end else if (code == CODE_TAB) begin
         for (int k = 0; k < TAB_SPACES; k++) r.screen_cleared |= store_char(CODE_SPACE);
      end else begin
         r.screen_cleared = store_char(code);
      end
      r.cursor_pos = cursor_now[CURSOR_W-1:0];
      return r;
   endfunction

   function automatic logic [CHAR_W-1:0] pick_text_char();
      int r;
      r = $urandom_range(0, 99);
      if (r < 10) return CODE_NEWLINE;
      else if (r < 20) return CODE_TAB;
      else if (r < 75) return CHAR_W'($urandom_range(32, 126));
      else return CHAR_W'($urandom_range(0, 255));
   endfunction

   function automatic logic [INDEX_W-1:0] pick_read_index();
      if ($urandom_range(0, 99) < 75) return INDEX_W'($urandom_range(0, cursor_now));
      else return INDEX_W'($urandom_range(0, 2047));
   endfunction

   always @(posedge clock) begin : check_responses
      console_result_type got;
      console_result_type want;
      if (!reset && rsp_strobe === 1'b1) begin
         got = {rsp_cursor_pos, rsp_read_char, rsp_read_attr, rsp_screen_cleared,
                rsp_last_of_text};
         if (pending_results.size() == 0) begin
            note_mismatch($sformatf({"unexpected response: cursor %0d char %h attr %h ",
                                     "clr %b eot %b"},
                                    got.cursor_pos, got.read_char, got.read_attr,
                                    got.screen_cleared, got.last_of_text));
         end else begin
            want = pending_results.pop_front();
            if (got !== want)
               note_mismatch($sformatf({"response mismatch: expected cursor %0d char %h ",
                                        "attr %h clr %b eot %b, got cursor %0d char %h ",
                                        "attr %h clr %b eot %b"},
                                       want.cursor_pos, want.read_char, want.read_attr,
                                       want.screen_cleared, want.last_of_text, got.cursor_pos,
                                       got.read_char, got.read_attr, got.screen_cleared,
                                       got.last_of_text));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe || (psel && penable)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("text_mode_console_writer_unit_tb NOT OK");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   task automatic send_request(input logic action, input logic [CHAR_W-1:0] code,
                               input logic [INDEX_W-1:0] index, input logic eot);
      start           <= 1'b1;
      req_action      <= action;
      req_char_code   <= code;
      req_cell_index  <= index;
      req_end_of_text <= eot;
      do @(posedge clock); while (busy !== 1'b0);
      pending_results.push_back(predict_console(action, code, index, eot));
      item_count++;
      @(negedge clock);
      if (!no_gaps && $urandom_range(0, 99) < 6) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 8)) @(negedge clock);
      end
   endtask

   task automatic put_char(input logic [CHAR_W-1:0] code, input logic eot);
      send_request(ACT_PUT, code, INDEX_W'($urandom_range(0, 2047)), eot);
   endtask

   task automatic read_cell(input int index, input logic eot);
      send_request(ACT_READ, CHAR_W'($urandom_range(0, 255)), INDEX_W'(index), eot);
   endtask

   // Hold start low until every response is in, then let the block settle.
   task automatic wait_drained();
      start <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic set_text_attribute(input logic [ATTR_W-1:0] value);
      wait_drained();
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= ATTR_ADDR;
      pwdata  <= APB_DATA_W'(value);
      @(negedge clock);
      penable <= 1'b1;
      @(negedge clock);
      text_attr = value;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      if (prdata !== APB_DATA_W'(value))
         note_mismatch($sformatf("attribute readback: expected %h, got %h", value, prdata));
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   // Advance to the last row with newlines, fill up to target, then send last_code.
   task automatic run_to_end(input int unsigned target, input logic [CHAR_W-1:0] last_code);
      while (cursor_now / COLUMNS < ROWS - 1) put_char(CODE_NEWLINE, 1'b0);
      while (cursor_now + TAB_SPACES <= target) put_char(CODE_TAB, 1'($urandom_range(0, 1)));
      while (cursor_now < target) put_char(CHAR_W'($urandom_range(33, 126)), 1'b0);
      put_char(last_code, 1'b1);
   endtask

   task automatic test_reset_state();
      read_cell(0, 1'b0);
      read_cell(CELL_COUNT - 1, 1'b1);
      read_cell(CELL_COUNT, 1'b0);
      read_cell(2047, 1'b1);
      wait_drained();
   endtask

   task automatic test_char_ops();
      put_char(8'h00, 1'b0);
      put_char(8'hFF, 1'b0);
      put_char(8'h41, 1'b1);
      put_char(CODE_TAB, 1'b0);
      put_char(CODE_NEWLINE, 1'b1);
      put_char(CODE_SPACE, 1'b0);
      for (int i = 0; i < 8; i++) read_cell(i, i[0]);
      read_cell(COLUMNS, 1'b0);
      wait_drained();
   endtask

   task automatic test_text_attribute();
      int base;
      set_text_attribute(8'hFF);
      put_char(8'h7E, 1'b0);
      put_char(CODE_TAB, 1'b1);
      set_text_attribute(8'h00);
      put_char(8'h5A, 1'b1);
      base = cursor_now - 6;
      for (int i = base; i < base + 7; i++) read_cell(i, 1'b0);
      wait_drained();
   endtask

   task automatic test_screen_wrap();
      run_to_end(0, CODE_NEWLINE);
      read_cell(0, 1'b0);
      set_text_attribute(8'h1E);
      run_to_end(CELL_COUNT, 8'h41);
      read_cell(0, 1'b0);
      read_cell(CELL_COUNT - 1, 1'b1);
      set_text_attribute(8'hA5);
      run_to_end(CELL_COUNT - 2, CODE_TAB);
      for (int i = 0; i < 3; i++) read_cell(i, 1'b0);
      read_cell(CELL_COUNT - 2, 1'b0);
      read_cell(CELL_COUNT - 1, 1'b1);
      run_to_end(CELL_COUNT, CODE_TAB);
      run_to_end(CELL_COUNT, CODE_NEWLINE);
      wait_drained();
   endtask

   task automatic random_sequence();
      int kind;
      int len;
      kind = $urandom_range(0, 99);
      if (kind < 58) begin
         len = $urandom_range(1, 16);
         for (int i = 0; i < len; i++) put_char(pick_text_char(), i == len - 1);
      end else if (kind < 83) begin
         len = $urandom_range(1, 6);
         for (int i = 0; i < len; i++) read_cell(pick_read_index(), 1'($urandom_range(0, 1)));
      end else if (kind < 91) begin
         run_to_end(CELL_COUNT - $urandom_range(0, 4), pick_text_char());
      end else begin
         send_request(1'($urandom_range(0, 1)), CHAR_W'($urandom_range(0, 255)),
                      INDEX_W'($urandom_range(0, 2047)), 1'($urandom_range(0, 1)));
      end
   endtask

   task automatic test_random_text();
      int goal;
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            1: set_text_attribute(8'hFF);
            2: set_text_attribute(8'h00);
            default: set_text_attribute(ATTR_W'($urandom_range(0, 255)));
         endcase
         no_gaps = (phase == 2);
         goal = item_count + RANDOM_ITEMS / 4;
         while (item_count < goal) random_sequence();
      end
      no_gaps = 1'b0;
   endtask

   initial begin : run_tests
      reset           = 1'b1;
      start           = 1'b0;
      req_action      = ACT_PUT;
      req_char_code   = '0;
      req_cell_index  = '0;
      req_end_of_text = 1'b0;
      psel            = 1'b0;
      penable         = 1'b0;
      pwrite          = 1'b0;
      paddr           = '0;
      pwdata          = '0;
      mismatch_count  = 0;
      item_count      = 0;
      stall_cycles    = 0;
      no_gaps         = 1'b0;
      text_attr       = RESET_ATTR;
      blank_screen();
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      do @(negedge clock); while (busy !== 1'b0);

      test_reset_state();
      test_char_ops();
      test_text_attribute();
      test_screen_wrap();
      test_random_text();
      wait_drained();

      if (mismatch_count == 0 && pending_results.size() == 0) begin
         $display("text_mode_console_writer_unit_tb OK");
      end else begin
         $display("text_mode_console_writer_unit_tb NOT OK");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
+incdir+hw/rtl
hw/rtl/tmcw_pkg.sv
hw/rtl/tmcw_csr.sv
hw/rtl/tmcw_ram.sv
hw/rtl/tmcw_ctrl.sv
hw/rtl/text_mode_console_writer_unit.sv
tb/text_mode_console_writer_unit_tb.sv
